>>> sv/tsac_pkg.sv
// Package: shared types and constants for the transmit-status coalescer.
package tsac_pkg;

   localparam int NUM_STATIONS  = 64;
   localparam int MAX_MERGED    = 32;
   localparam int STATION_IDX_W = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
   localparam int COUNT_W       = 6;
   localparam int PRESENT_W     = 64;
   localparam int MASK_W        = 8;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 64;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_PRESENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_MASK      = 2'd1;

   localparam logic [MASK_W-1:0] PROBE_MASK_RESET = 8'h80;

   typedef struct packed {
      logic [7:0]  station_id;
      logic [7:0]  packet_tag;
      logic        ack_requested;
      logic        aggregated;
      logic        delivered;
      logic [3:0]  retry_count;
      logic [15:0] rate_word;
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      status_type         status;
   } cache_entry_type;

   localparam int CACHE_W = $bits(cache_entry_type);

   typedef struct packed {
      logic       batch_start;
      logic       known;
      logic       candidate;
      status_type status;
   } queue_item_type;

endpackage

>>> sv/tsac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tsac_front.sv
// Front end: accepts status entries and classifies them for the back end.
module tsac_front import tsac_pkg::*; (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_batch_start,
   input  logic [7:0]           req_station_id,
   input  logic [15:0]          req_rate_word,
   input  logic [3:0]           req_retry_count,
   input  logic                 req_delivered,
   input  logic                 req_aggregated,
   input  logic                 req_ack_requested,
   input  logic [7:0]           req_packet_tag,
   input  logic [PRESENT_W-1:0] station_present,
   input  logic                 queue_full,
   output logic                 queue_push,
   output queue_item_type       queue_item
);

   logic in_range;
   logic known;

   always_comb begin
      in_range = {1'b0, req_station_id} < 9'(NUM_STATIONS);
      known    = in_range && station_present[req_station_id[STATION_IDX_W-1:0]];
   end

   always_comb begin
      queue_item.batch_start          = req_batch_start;
      queue_item.known                = known;
      queue_item.candidate            = known && req_aggregated;
      queue_item.status.station_id    = req_station_id;
      queue_item.status.packet_tag    = req_packet_tag;
      queue_item.status.ack_requested = req_ack_requested;
      queue_item.status.aggregated    = req_aggregated;
      queue_item.status.delivered     = req_delivered;
      queue_item.status.retry_count   = req_retry_count;
      queue_item.status.rate_word     = req_rate_word;
   end

   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

endmodule

>>> sv/tsac_queue.sv
// Small register queue between the front and back ends.
module tsac_queue import tsac_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  queue_item_type push_item,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output queue_item_type head_item
);

   queue_item_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_item = mem_ff[rd_ptr_ff];

endmodule

>>> sv/tsac_back.sv
// Back end: per-station cache lookup, merge decision and report register.
module tsac_back import tsac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_not_empty,
   input  queue_item_type    queue_head,
   output logic              queue_pop,
   input  logic [MASK_W-1:0] probe_mask,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_report_station,
   output logic              rsp_station_known,
   output logic [15:0]       rsp_report_rate,
   output logic [3:0]        rsp_report_retry,
   output logic [5:0]        rsp_frames,
   output logic [5:0]        rsp_acked_frames,
   output logic              rsp_is_probe,
   output logic              rsp_is_aggregate,
   output logic              rsp_no_ack,
   output logic              rsp_acked
);

   // lookup stage
   logic                     b_valid_ff, b_valid_in;
   queue_item_type           b_item_ff;
   logic                     b_byp_ff, b_byp_in;
   cache_entry_type          b_byp_data_ff;
   logic                     b_vld_ff, b_vld_in;
   logic [NUM_STATIONS-1:0]  valid_ff, valid_in;
   logic                     flush_ff, flush_in;

   // report register
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_station_ff;
   logic                     out_known_ff;
   logic [15:0]              out_rate_ff;
   logic [3:0]               out_retry_ff;
   logic [5:0]               out_frames_ff;
   logic [5:0]               out_acked_frames_ff;
   logic                     out_probe_ff;
   logic                     out_agg_ff;
   logic                     out_no_ack_ff;
   logic                     out_acked_ff;

   logic                     b_fire;
   logic                     merge;
   logic                     flush_now;
   logic                     same;
   cache_entry_type          ram_q;
   cache_entry_type          cache;
   cache_entry_type          wr_data;
   logic                     wr_en;
   logic [STATION_IDX_W-1:0] wr_addr;
   logic [STATION_IDX_W-1:0] rd_addr;
   status_type               rep_status;
   logic [COUNT_W-1:0]       rep_count;

   assign b_fire    = b_valid_ff && (!out_valid_ff || rsp_ready);
   assign queue_pop = queue_not_empty && (!b_valid_ff || b_fire);
   assign rd_addr   = queue_head.status.station_id[STATION_IDX_W-1:0];
   assign wr_addr   = b_item_ff.status.station_id[STATION_IDX_W-1:0];

   tsac_ram #(
      .WIDTH (CACHE_W),
      .DEPTH (NUM_STATIONS)
   ) u_cache_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (queue_pop),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      if (b_byp_ff) begin
         cache = b_byp_data_ff;
      end else if (b_vld_ff) begin
         cache = ram_q;
      end else begin
         cache = '0;
      end
      flush_now = b_item_ff.batch_start || flush_ff;
      same      = (cache.status.rate_word == b_item_ff.status.rate_word) &&
                  (cache.status.retry_count == b_item_ff.status.retry_count) &&
                  (cache.status.station_id == b_item_ff.status.station_id);
      merge     = b_item_ff.candidate && !flush_now && same &&
                  (cache.count < COUNT_W'(MAX_MERGED));
   end

   always_comb begin
      wr_en   = b_fire && b_item_ff.candidate;
      wr_data = '0;
      if (merge) begin
         wr_data.status = cache.status;
         wr_data.count  = cache.count + 1'b1;
      end else begin
         wr_data.status = b_item_ff.status;
         wr_data.count  = COUNT_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      b_byp_in = wr_en && (wr_addr == rd_addr);
      b_vld_in = valid_ff[rd_addr] || b_byp_in;
      if (queue_pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
      flush_in = flush_ff;
      if (b_fire) begin
         if (!b_item_ff.candidate) begin
            flush_in = 1'b1;
         end else if (merge) begin
            flush_in = flush_now;
         end else begin
            flush_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (b_item_ff.candidate) begin
         rep_status = cache.status;
         rep_count  = cache.count;
      end else begin
         rep_status = b_item_ff.status;
         rep_count  = COUNT_W'(1);
      end
      if (b_fire && !merge) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         valid_ff     <= '0;
         flush_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         valid_ff     <= valid_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         b_item_ff     <= queue_head;
         b_byp_ff      <= b_byp_in;
         b_byp_data_ff <= wr_data;
         b_vld_ff      <= b_vld_in;
      end
      if (b_fire && !merge) begin
         out_station_ff <= b_item_ff.status.station_id;
         out_known_ff   <= b_item_ff.known;
         if (rep_count == '0) begin
            out_rate_ff         <= '0;
            out_retry_ff        <= '0;
            out_frames_ff       <= '0;
            out_acked_frames_ff <= '0;
            out_probe_ff        <= 1'b0;
            out_agg_ff          <= 1'b0;
            out_no_ack_ff       <= 1'b0;
            out_acked_ff        <= 1'b0;
         end else begin
            out_rate_ff         <= rep_status.rate_word;
            out_retry_ff        <= rep_status.retry_count;
            out_frames_ff       <= rep_count;
            out_acked_frames_ff <= rep_status.delivered ? rep_count : '0;
            out_probe_ff        <= |(rep_status.packet_tag & probe_mask);
            out_agg_ff          <= rep_status.aggregated;
            out_no_ack_ff       <= !rep_status.ack_requested;
            out_acked_ff        <= rep_status.ack_requested && rep_status.delivered;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_report_station = out_station_ff;
   assign rsp_station_known  = out_known_ff;
   assign rsp_report_rate    = out_rate_ff;
   assign rsp_report_retry   = out_retry_ff;
   assign rsp_frames         = out_frames_ff;
   assign rsp_acked_frames   = out_acked_frames_ff;
   assign rsp_is_probe       = out_probe_ff;
   assign rsp_is_aggregate   = out_agg_ff;
   assign rsp_no_ack         = out_no_ack_ff;
   assign rsp_acked          = out_acked_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_data.count != '0) && (wr_data.count <= COUNT_W'(MAX_MERGED)))
      else $error("cache count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !(b_fire && !merge))
      else $error("pending report overwritten");

   a_flush_after_single: assert property (@(posedge clock) disable iff (reset)
      (b_fire && !b_item_ff.candidate) |=> flush_ff)
      else $error("flush flag not set after single report");

   a_bypass_needs_write: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && b_byp_in) |-> (b_fire && b_item_ff.candidate))
      else $error("bypass without cache write");

endmodule

>>> sv/tsac_top.sv
// Top level: transmit-status coalescer with configuration registers.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | one transmit-status entry
//   rsp_    | out       | rsp_valid / rsp_ready | zero or one report per entry
//   csr_    | in        | csr_valid / csr_ready | register index and write data
//
// One entry per cycle sustained unless a stalled report register holds the flow; a
// report passes the queue, the cache RAM read in the lookup stage, then the report register.
// The per-station cache RAM has registered read; a write to the station being
// read in the same cycle is forwarded. Reset clears one valid bit per station,
// so the cache reads as zero at once, with no clearing pass.
// A stalled report register holds the lookup stage; the queue absorbs entries
// until full.
module tx_status_aggregation_coalescer_top import tsac_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_batch_start,
   input  logic [7:0]             req_station_id,
   input  logic [15:0]            req_rate_word,
   input  logic [3:0]             req_retry_count,
   input  logic                   req_delivered,
   input  logic                   req_aggregated,
   input  logic                   req_ack_requested,
   input  logic [7:0]             req_packet_tag,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_report_station,
   output logic                   rsp_station_known,
   output logic [15:0]            rsp_report_rate,
   output logic [3:0]             rsp_report_retry,
   output logic [5:0]             rsp_frames,
   output logic [5:0]             rsp_acked_frames,
   output logic                   rsp_is_probe,
   output logic                   rsp_is_aggregate,
   output logic                   rsp_no_ack,
   output logic                   rsp_acked,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [PRESENT_W-1:0] station_present_ff, station_present_in;
   logic [MASK_W-1:0]    probe_mask_ff, probe_mask_in;

   logic                 queue_full;
   logic                 queue_push;
   queue_item_type       push_item;
   logic                 queue_pop;
   logic                 queue_not_empty;
   queue_item_type       head_item;

   assign csr_ready = 1'b1;

   always_comb begin
      station_present_in = station_present_ff;
      probe_mask_in      = probe_mask_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STATION_PRESENT: station_present_in = csr_data[PRESENT_W-1:0];
            CSR_PROBE_MASK:      probe_mask_in      = csr_data[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_present_ff <= '0;
         probe_mask_ff      <= PROBE_MASK_RESET;
      end else begin
         station_present_ff <= station_present_in;
         probe_mask_ff      <= probe_mask_in;
      end
   end

   tsac_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_batch_start   (req_batch_start),
      .req_station_id    (req_station_id),
      .req_rate_word     (req_rate_word),
      .req_retry_count   (req_retry_count),
      .req_delivered     (req_delivered),
      .req_aggregated    (req_aggregated),
      .req_ack_requested (req_ack_requested),
      .req_packet_tag    (req_packet_tag),
      .station_present   (station_present_ff),
      .queue_full        (queue_full),
      .queue_push        (queue_push),
      .queue_item        (push_item)
   );

   tsac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   tsac_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_not_empty    (queue_not_empty),
      .queue_head         (head_item),
      .queue_pop          (queue_pop),
      .probe_mask         (probe_mask_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_report_station (rsp_report_station),
      .rsp_station_known  (rsp_station_known),
      .rsp_report_rate    (rsp_report_rate),
      .rsp_report_retry   (rsp_report_retry),
      .rsp_frames         (rsp_frames),
      .rsp_acked_frames   (rsp_acked_frames),
      .rsp_is_probe       (rsp_is_probe),
      .rsp_is_aggregate   (rsp_is_aggregate),
      .rsp_no_ack         (rsp_no_ack),
      .rsp_acked          (rsp_acked)
   );

endmodule

>>> bench/tx_status_aggregation_coalescer_top_test.sv
// Testbench for the transmit-status coalescer: directed table, then random runs per config.
`timescale 1ns / 1ps

module tx_status_aggregation_coalescer_top_test;
   import tsac_pkg::*;

   typedef struct packed {
      logic       batch_start;
      status_type status;
   } entry_type;

   typedef struct packed {
      logic [7:0]  station;
      logic        known;
      logic [15:0] rate;
      logic [3:0]  retry;
      logic [5:0]  frames;
      logic [5:0]  acked_frames;
      logic        probe;
      logic        aggr;
      logic        no_ack;
      logic        acked;
   } report_type;

   typedef enum logic [1:0] {ROW_ENTRY, ROW_PRESENT, ROW_MASK} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         batch;
      logic [7:0]   sid;
      logic [15:0]  rate;
      logic [3:0]   retry;
      logic         ok;
      logic         aggr;
      logic         ackreq;
      logic [7:0]   tag;
      logic [63:0]  value;
      logic         typed;
      report_type   want;
   } step_row_type;

   localparam step_row_type DIRECTED_STEPS [26] = '{
      // nothing present yet: every entry reports at once
      '{ROW_ENTRY, 1'b0, 8'd0, 16'h0000, 4'h0, 1'b0, 1'b1, 1'b0, 8'h80, 64'd0, 1'b1,
        '{8'd0, 1'b0, 16'h0000, 4'h0, 6'd1, 6'd0, 1'b1, 1'b1, 1'b1, 1'b0}},
      '{ROW_ENTRY, 1'b1, 8'd255, 16'hFFFF, 4'hF, 1'b1, 1'b1, 1'b1, 8'hFF, 64'd0, 1'b1,
        '{8'd255, 1'b0, 16'hFFFF, 4'hF, 6'd1, 6'd1, 1'b1, 1'b1, 1'b0, 1'b1}},
      '{ROW_ENTRY, 1'b0, 8'd1, 16'h1234, 4'h5, 1'b1, 1'b0, 1'b1, 8'h7F, 64'd0, 1'b1,
        '{8'd1, 1'b0, 16'h1234, 4'h5, 6'd1, 6'd1, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{ROW_PRESENT, 1'b0, 8'd0, 16'h0, 4'h0, 1'b0, 1'b0, 1'b0, 8'h0, {64{1'b1}}, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd7, 16'h0000, 4'h0, 1'b1, 1'b1, 1'b1, 8'h00, 64'd0, 1'b1,
        '{8'd7, 1'b1, 16'h0000, 4'h0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // station 0 merges into the all-zero cache left by reset
      '{ROW_ENTRY, 1'b0, 8'd0, 16'h0000, 4'h0, 1'b1, 1'b1, 1'b1, 8'h00, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd0, 16'h0000, 4'h0, 1'b0, 1'b1, 1'b0, 8'h80, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd0, 16'h0000, 4'h0, 1'b1, 1'b1, 1'b1, 8'h01, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd0, 16'h0001, 4'h0, 1'b0, 1'b1, 1'b0, 8'h00, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd5, 16'h1234, 4'h3, 1'b1, 1'b1, 1'b0, 8'h80, 64'd0, 1'b1,
        '{8'd5, 1'b1, 16'h0000, 4'h0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_ENTRY, 1'b0, 8'd5, 16'h1234, 4'h3, 1'b0, 1'b1, 1'b1, 8'h80, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd5, 16'h1234, 4'h4, 1'b1, 1'b1, 1'b1, 8'h80, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b1, 8'd5, 16'h1234, 4'h4, 1'b1, 1'b1, 1'b1, 8'h80, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd5, 16'h1234, 4'h4, 1'b0, 1'b0, 1'b0, 8'h00, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd5, 16'h1234, 4'h4, 1'b1, 1'b1, 1'b1, 8'h80, 64'd0, 1'b0, '0},
      // id beyond the station table
      '{ROW_ENTRY, 1'b0, 8'd64, 16'hABCD, 4'h9, 1'b1, 1'b1, 1'b0, 8'h80, 64'd0, 1'b1,
        '{8'd64, 1'b0, 16'hABCD, 4'h9, 6'd1, 6'd1, 1'b1, 1'b1, 1'b1, 1'b0}},
      '{ROW_ENTRY, 1'b0, 8'd63, 16'h5555, 4'hA, 1'b0, 1'b1, 1'b1, 8'hFF, 64'd0, 1'b1,
        '{8'd63, 1'b1, 16'h0000, 4'h0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_MASK, 1'b0, 8'd0, 16'h0, 4'h0, 1'b0, 1'b0, 1'b0, 8'h0, 64'h0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd63, 16'h5555, 4'hA, 1'b1, 1'b1, 1'b0, 8'hFF, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd63, 16'h5555, 4'hB, 1'b1, 1'b1, 1'b0, 8'hFF, 64'd0, 1'b0, '0},
      '{ROW_MASK, 1'b0, 8'd0, 16'h0, 4'h0, 1'b0, 1'b0, 1'b0, 8'h0, 64'hFF, 1'b0, '0},
      '{ROW_PRESENT, 1'b0, 8'd0, 16'h0, 4'h0, 1'b0, 1'b0, 1'b0, 8'h0, 64'hAAAA_AAAA_AAAA_AAAA,
        1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd2, 16'h0F0F, 4'h1, 1'b0, 1'b1, 1'b1, 8'h01, 64'd0, 1'b1,
        '{8'd2, 1'b0, 16'h0F0F, 4'h1, 6'd1, 6'd0, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{ROW_ENTRY, 1'b0, 8'd3, 16'h0F0F, 4'h1, 1'b1, 1'b1, 1'b1, 8'h01, 64'd0, 1'b1,
        '{8'd3, 1'b1, 16'h0000, 4'h0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_ENTRY, 1'b0, 8'd3, 16'h0F0F, 4'h1, 1'b1, 1'b1, 1'b1, 8'h01, 64'd0, 1'b0, '0},
      '{ROW_ENTRY, 1'b0, 8'd3, 16'h0F0F, 4'h1, 1'b1, 1'b0, 1'b1, 8'h01, 64'd0, 1'b0, '0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_batch_start = 1'b0;
   logic [7:0]             req_station_id = 8'd0;
   logic [15:0]            req_rate_word = 16'd0;
   logic [3:0]             req_retry_count = 4'd0;
   logic                   req_delivered = 1'b0;
   logic                   req_aggregated = 1'b0;
   logic                   req_ack_requested = 1'b0;
   logic [7:0]             req_packet_tag = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_report_station;
   logic                   rsp_station_known;
   logic [15:0]            rsp_report_rate;
   logic [3:0]             rsp_report_retry;
   logic [5:0]             rsp_frames;
   logic [5:0]             rsp_acked_frames;
   logic                   rsp_is_probe;
   logic                   rsp_is_aggregate;
   logic                   rsp_no_ack;
   logic                   rsp_acked;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_STATION_PRESENT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   tx_status_aggregation_coalescer_top dut (.*);

   status_type  cached_status [NUM_STATIONS];
   logic [5:0]  cached_count [NUM_STATIONS];
   logic        flush_pending;
   logic [63:0] present_bits;
   logic [7:0]  probe_mask;

   report_type  pending_reports [$];
   bit          tx_quiet = 1'b0;
   int          mismatch_count = 0;
   int          entries_sent = 0;
   int          merged_entries = 0;
   int          reports_checked = 0;
   int          empty_reports = 0;
   int          full_reports = 0;
   int          csr_writes = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** tx_status_aggregation_coalescer_top: FAILED **");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < 100)
         $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic string describe(input report_type r);
      return {$sformatf("sta %0d known %0b rate %h retry %0d frames %0d acked_frames %0d",
                        r.station, r.known, r.rate, r.retry, r.frames, r.acked_frames),
              $sformatf(" probe %0b agg %0b no_ack %0b acked %0b",
                        r.probe, r.aggr, r.no_ack, r.acked)};
   endfunction

   function automatic report_type build_report(input logic [7:0] sid, input logic known,
                                               input status_type w, input logic [5:0] n);
      report_type r;
      r = '0;
      r.station = sid;
      r.known = known;
      if (n != 6'd0) begin
         r.rate = w.rate_word;
         r.retry = w.retry_count;
         r.frames = n;
         r.acked_frames = w.delivered ? n : 6'd0;
         r.probe = |(w.packet_tag & probe_mask);
         r.aggr = w.aggregated;
         r.no_ack = !w.ack_requested;
         r.acked = w.ack_requested && w.delivered;
      end
      return r;
   endfunction

   // Returns 1 when the entry produces a report.
   function automatic bit coalesce_entry(input entry_type e, output report_type r);
      status_type                 s;
      status_type                 c;
      logic                       known;
      logic [5:0]                 n;
      logic [STATION_IDX_W-1:0]   slot;
      s = e.status;
      r = '0;
      if (e.batch_start)
         flush_pending = 1'b1;
      known = 1'b0;
      slot = s.station_id[STATION_IDX_W-1:0];
      if (int'(s.station_id) < NUM_STATIONS)
         known = present_bits[slot];
      if (known && s.aggregated) begin
         c = cached_status[slot];
         n = cached_count[slot];
         if (!flush_pending && c.rate_word == s.rate_word && c.retry_count == s.retry_count
             && c.station_id == s.station_id && int'(n) < MAX_MERGED) begin
            cached_count[slot] = n + 6'd1;
            return 1'b0;
         end
         r = build_report(s.station_id, known, c, n);
         cached_status[slot] = s;
         cached_count[slot] = 6'd1;
         flush_pending = 1'b0;
         return 1'b1;
      end
      r = build_report(s.station_id, known, s, 6'd1);
      flush_pending = 1'b1;
      return 1'b1;
   endfunction

   task automatic push_entry(input entry_type e, input bit use_typed, input report_type typed);
      report_type predicted;
      int         gap;
      if ($urandom_range(0, 29) == 0)
         tx_quiet = !tx_quiet;
      gap = tx_quiet ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_batch_start <= e.batch_start;
      req_station_id <= e.status.station_id;
      req_rate_word <= e.status.rate_word;
      req_retry_count <= e.status.retry_count;
      req_delivered <= e.status.delivered;
      req_aggregated <= e.status.aggregated;
      req_ack_requested <= e.status.ack_requested;
      req_packet_tag <= e.status.packet_tag;
      do @(posedge clock); while (!req_ready);
      entries_sent++;
      if (coalesce_entry(e, predicted))
         pending_reports.push_back(use_typed ? typed : predicted);
      else
         merged_entries++;
   endtask

   // Wait until all reports are back, with slack for merges still in the pipe.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (idx)
         CSR_STATION_PRESENT: present_bits = value;
         CSR_PROBE_MASK:      probe_mask = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_station();
      logic [7:0] s;
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom());
      s = 8'($urandom_range(0, 63));
      for (int k = 0; k < 8 && !present_bits[s[STATION_IDX_W-1:0]]; k++)
         s = 8'($urandom_range(0, 63));
      return s;
   endfunction

   // Mostly runs of matching aggregated entries for one station; some runs broken, some noise.
   task automatic send_random_phase(input int quota);
      entry_type  e;
      int         sent;
      int         run_len;
      bit         broken;
      logic [7:0] sid;
      logic [15:0] rate;
      logic [3:0] retry;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) begin
               e = entry_type'(40'({$urandom(), $urandom()}));
               push_entry(e, 1'b0, '0);
               sent++;
            end
         end
         sid = pick_station();
         rate = 16'($urandom());
         retry = 4'($urandom());
         run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
         broken = ($urandom_range(0, 3) == 0);
         repeat (run_len) begin
            e.batch_start = 1'b0;
            e.status.station_id = sid;
            e.status.rate_word = rate;
            e.status.retry_count = retry;
            e.status.delivered = 1'($urandom());
            e.status.aggregated = 1'b1;
            e.status.ack_requested = 1'($urandom());
            e.status.packet_tag = 8'($urandom());
            if (broken && $urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 2))
                  0: e.batch_start = 1'b1;
                  1: e.status.aggregated = 1'b0;
                  default: e.status.retry_count = 4'($urandom());
               endcase
            end
            push_entry(e, 1'b0, '0);
            sent++;
         end
      end
   endtask

   initial begin
      report_type got;
      report_type want;
      int         gap;
      bit         rx_quiet;
      rx_quiet = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 29) == 0)
            rx_quiet = !rx_quiet;
         gap = rx_quiet ? 0 : $urandom_range(0, 17);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_report_station, rsp_station_known, rsp_report_rate, rsp_report_retry,
                 rsp_frames, rsp_acked_frames, rsp_is_probe, rsp_is_aggregate, rsp_no_ack,
                 rsp_acked};
         reports_checked++;
         if (got.frames == 6'd0)
            empty_reports++;
         if (int'(got.frames) == MAX_MERGED)
            full_reports++;
         if (pending_reports.size() == 0) begin
            flag_mismatch({"unexpected report: ", describe(got)});
         end else begin
            want = pending_reports.pop_front();
            if (got !== want)
               flag_mismatch({"got ", describe(got), " expected ", describe(want)});
         end
      end
   end

   initial begin
      entry_type    e;
      step_row_type row;
      logic [63:0]  phase_present [6];
      logic [7:0]   phase_mask [6];
      for (int i = 0; i < NUM_STATIONS; i++) begin
         cached_status[i] = '0;
         cached_count[i] = '0;
      end
      flush_pending = 1'b1;
      present_bits = '0;
      probe_mask = PROBE_MASK_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_STEPS[i]) begin
         row = DIRECTED_STEPS[i];
         if (row.kind == ROW_ENTRY) begin
            e.batch_start = row.batch;
            e.status.station_id = row.sid;
            e.status.rate_word = row.rate;
            e.status.retry_count = row.retry;
            e.status.delivered = row.ok;
            e.status.aggregated = row.aggr;
            e.status.ack_requested = row.ackreq;
            e.status.packet_tag = row.tag;
            push_entry(e, row.typed, row.want);
         end else begin
            settle();
            write_csr(row.kind == ROW_PRESENT ? CSR_STATION_PRESENT : CSR_PROBE_MASK,
                      row.value);
         end
      end

      phase_present = '{{64{1'b1}}, {$urandom(), $urandom()}, 64'd0, {64{1'b1}},
                        64'h8000_0000_0000_0001, {64{1'b1}}};
      phase_mask = '{8'h80, 8'($urandom()), 8'hFF, 8'h00, 8'h01, 8'($urandom())};
      for (int p = 0; p < 6; p++) begin
         settle();
         write_csr(CSR_STATION_PRESENT, phase_present[p]);
         write_csr(CSR_PROBE_MASK, {56'({$urandom(), $urandom()}), phase_mask[p]});
         send_random_phase(225);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      for (int w = 0; w < 4000 && pending_reports.size() != 0; w++)
         @(posedge clock);
      if (pending_reports.size() != 0)
         flag_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
      repeat (12) @(posedge clock);

      $display("Coverage: %0d status entries, %0d merged, %0d config writes",
               entries_sent, merged_entries, csr_writes);
      $display("Coverage: %0d reports checked, %0d empty, %0d at the merge limit, %0d bad",
               reports_checked, empty_reports, full_reports, mismatch_count);
      if (mismatch_count == 0)
         $display("** tx_status_aggregation_coalescer_top: PASSED **");
      else
         $display("** tx_status_aggregation_coalescer_top: FAILED **");
      $finish;
   end

endmodule
